@@ design/ffa_pkg.sv @@
// shared codes and types for the first-fit heap allocator
package ffa_pkg;

    localparam int RES_ADDR_W = 13;
    localparam int STATUS_W   = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd6;

    typedef struct packed {
        logic                  valid;
        logic [RES_ADDR_W-1:0] addr;
        logic [STATUS_W-1:0]   status;
    } res_t;

endpackage

@@ design/ffa_ram.sv @@
// generic single-write, single-read ram with registered read data
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ffa_ctrl.sv @@
// sequencer that walks the header list through one shared adder
module ffa_ctrl #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          op,
    input  logic [15:0]   req_size,
    input  logic [15:0]   payload_addr,
    output logic          busy,
    output ffa_pkg::res_t res
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int W  = AW + 1;

    localparam logic [W-1:0] HEAP_W  = W'(HEAP_BYTES);
    localparam logic [W-1:0] HDR_W   = W'(HEADER_BYTES);
    localparam logic [W-1:0] FIRST_W = W'(HEAP_BYTES - HEADER_BYTES);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ACHK = 3'd2;
    localparam logic [2:0] S_ASPL = 3'd3;
    localparam logic [2:0] S_FCHK = 3'd4;
    localparam logic [2:0] S_FNXT = 3'd5;
    localparam logic [2:0] S_FPRV = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] req_reg, req_next;
    logic [W-1:0] tgt_reg, tgt_next;
    logic [W-1:0] prev_reg, prev_next;
    logic [W-1:0] psize_reg, psize_next;
    logic [W-1:0] asize_reg, asize_next;
    logic         pfree_reg, pfree_next;
    logic         hasprev_reg, hasprev_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [W:0]    wdata;
    logic [AW-1:0] raddr;
    logic [W:0]    rdata;
    logic          rd_free;
    logic [W-1:0]  rd_size;

    logic [W-1:0] add_x, add_y, sum;
    logic         fit, split;
    logic [16:0]  target_w;
    logic [W-1:0] merged;

    ffa_ram #(
        .WIDTH(W + 1),
        .DEPTH(HEAP_BYTES)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_free = rdata[W];
    assign rd_size = rdata[W-1:0];

    assign fit      = rd_free && (rd_size >= req_reg);
    assign split    = rd_size > (req_reg + HDR_W);
    assign target_w = {1'b0, payload_addr} - 17'(HEADER_BYTES);
    assign merged   = rd_free ? sum : asize_reg;

    // shared adder: offset or size plus header plus size
    always_comb
    begin
        add_x = a_reg;
        add_y = rd_size;
        unique case (state_reg)
            S_ACHK:
            begin
                add_y = fit ? req_reg : rd_size;
            end
            S_FNXT:
            begin
                add_x = asize_reg;
            end
            S_FPRV:
            begin
                add_x = psize_reg;
                add_y = asize_reg;
            end
            default:
            begin
                add_x = a_reg;
            end
        endcase
    end

    assign sum  = add_x + add_y + HDR_W;
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        req_next     = req_reg;
        tgt_next     = tgt_reg;
        prev_next    = prev_reg;
        psize_next   = psize_reg;
        asize_next   = asize_reg;
        pfree_next   = pfree_reg;
        hasprev_next = hasprev_reg;
        we           = 1'b0;
        waddr        = a_reg[AW-1:0];
        wdata        = {1'b1, rd_size};
        raddr        = sum[AW-1:0];
        res.valid    = 1'b0;
        res.addr     = '0;
        res.status   = ffa_pkg::ST_OK;

        unique case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = {1'b1, FIRST_W};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                raddr        = '0;
                a_next       = '0;
                hasprev_next = 1'b0;
                req_next     = W'(req_size);
                tgt_next     = W'(target_w);
                if (start)
                begin
                    if (op == ffa_pkg::OP_ALLOC)
                    begin
                        if (req_size == 16'd0)
                        begin
                            res.valid  = 1'b1;
                            res.status = ffa_pkg::ST_ZERO_SIZE;
                        end
                        else if ({1'b0, req_size} > 17'(HEAP_BYTES - HEADER_BYTES))
                        begin
                            res.valid  = 1'b1;
                            res.status = ffa_pkg::ST_TOO_LARGE;
                        end
                        else
                        begin
                            state_next = S_ACHK;
                        end
                    end
                    else
                    begin
                        if (payload_addr == 16'd0 ||
                            {1'b0, payload_addr} > 17'(HEAP_BYTES))
                        begin
                            res.valid  = 1'b1;
                            res.status = ffa_pkg::ST_BAD_RANGE;
                        end
                        else if ({1'b0, payload_addr} < 17'(HEADER_BYTES))
                        begin
                            res.valid  = 1'b1;
                            res.status = ffa_pkg::ST_INVALID;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                end
            end
            S_ACHK:
            begin
                if (fit)
                begin
                    if (split)
                    begin
                        // remainder becomes a new free block after the grant
                        we         = 1'b1;
                        waddr      = sum[AW-1:0];
                        wdata      = {1'b1, rd_size - req_reg - HDR_W};
                        state_next = S_ASPL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wdata      = {1'b0, rd_size};
                        res.valid  = 1'b1;
                        res.addr   = ffa_pkg::RES_ADDR_W'(a_reg + HDR_W);
                        state_next = S_IDLE;
                    end
                end
                else if (sum >= HEAP_W)
                begin
                    res.valid  = 1'b1;
                    res.status = ffa_pkg::ST_NO_SPACE;
                    state_next = S_IDLE;
                end
                else
                begin
                    a_next = sum;
                end
            end
            S_ASPL:
            begin
                we         = 1'b1;
                wdata      = {1'b0, req_reg};
                res.valid  = 1'b1;
                res.addr   = ffa_pkg::RES_ADDR_W'(a_reg + HDR_W);
                state_next = S_IDLE;
            end
            S_FCHK:
            begin
                if (a_reg == tgt_reg)
                begin
                    asize_next = rd_size;
                    if (rd_free)
                    begin
                        res.valid  = 1'b1;
                        res.status = ffa_pkg::ST_DBL_FREE;
                        state_next = S_IDLE;
                    end
                    else if (sum < HEAP_W)
                    begin
                        state_next = S_FNXT;
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = {1'b1, rd_size};
                        if (hasprev_reg && pfree_reg)
                        begin
                            state_next = S_FPRV;
                        end
                        else
                        begin
                            res.valid  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    prev_next    = a_reg;
                    psize_next   = rd_size;
                    pfree_next   = rd_free;
                    hasprev_next = 1'b1;
                    if (sum >= HEAP_W)
                    begin
                        res.valid  = 1'b1;
                        res.status = ffa_pkg::ST_INVALID;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        a_next = sum;
                    end
                end
            end
            S_FNXT:
            begin
                // absorb a free next block, the last one included
                we         = 1'b1;
                wdata      = {1'b1, merged};
                asize_next = merged;
                if (hasprev_reg && pfree_reg)
                begin
                    state_next = S_FPRV;
                end
                else
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FPRV:
            begin
                we         = 1'b1;
                waddr      = prev_reg[AW-1:0];
                wdata      = {1'b1, sum};
                res.valid  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        req_reg     <= req_next;
        tgt_reg     <= tgt_next;
        prev_reg    <= prev_next;
        psize_reg   <= psize_next;
        asize_reg   <= asize_next;
        pfree_reg   <= pfree_next;
        hasprev_reg <= hasprev_next;
    end

endmodule

@@ design/first_fit_heap_allocator.sv @@
// top level of the first-fit heap allocator with coalescing
//
//  channel   ports                                   handshake
//  request   op, req_size, payload_addr              start high, busy low
//  result    result_addr, status                     done, one cycle
//
//  a rejected request gives its result in the cycle after it is taken
//  an allocate walks the headers to the first fit, then writes any split
//  remainder and its own header
//  a free walks the headers up to its block and merges free neighbours
//  after reset the init state writes the first header, with busy high
//  the receiver cannot stall: each result is shown for one cycle only
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               op,
    input  logic [15:0]                        req_size,
    input  logic [15:0]                        payload_addr,
    output logic                               busy,
    output logic                               done,
    output logic [ffa_pkg::RES_ADDR_W-1:0]     result_addr,
    output logic [ffa_pkg::STATUS_W-1:0]       status
);

    ffa_pkg::res_t res;

    logic                           done_reg;
    logic [ffa_pkg::RES_ADDR_W-1:0] addr_reg;
    logic [ffa_pkg::STATUS_W-1:0]   status_reg;

    ffa_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .req_size    (req_size),
        .payload_addr(payload_addr),
        .busy        (busy),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            addr_reg   <= res.addr;
            status_reg <= res.status;
        end
    end

    assign done        = done_reg;
    assign result_addr = addr_reg;
    assign status      = status_reg;

endmodule

@@ design/ffa_checker.sv @@
// port-level checks for the allocator, bound to the top level
module ffa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           op,
    input logic                           busy,
    input logic                           done,
    input logic [ffa_pkg::RES_ADDR_W-1:0] result_addr,
    input logic [ffa_pkg::STATUS_W-1:0]   status
);

    logic accept;

    assign accept = start && !busy;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ffa_pkg::ST_DBL_FREE))
        else $error("status code out of range");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ffa_pkg::ST_OK) |-> (result_addr == '0))
        else $error("failed request returned an address");

    a_free_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == ffa_pkg::OP_FREE) |=> (busy || result_addr == '0))
        else $error("free returned an address");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("item taken but neither busy nor done");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(accept)))
        else $error("result with no item in work");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .op          (op),
    .busy        (busy),
    .done        (done),
    .result_addr (result_addr),
    .status      (status)
);

@@ sim/tb_top.sv @@
// testbench for the first-fit heap allocator, checked against a heap model
`timescale 1ns / 100ps

module tb_top;

    localparam int HEAP          = 4096;
    localparam int HDR           = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [ffa_pkg::RES_ADDR_W-1:0] addr;
        logic [ffa_pkg::STATUS_W-1:0]   status;
    } grant_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           op;
    logic [15:0]                    req_size;
    logic [15:0]                    payload_addr;
    logic                           busy;
    logic                           done;
    logic [ffa_pkg::RES_ADDR_W-1:0] result_addr;
    logic [ffa_pkg::STATUS_W-1:0]   status;

    // heap image: payload size and free flag per header offset
    int unsigned blk_size [HEAP];
    bit          blk_free [HEAP];

    grant_t      pending_grants[$];
    grant_t      last_grant;
    logic [15:0] live_ptrs[$];
    logic [15:0] freed_ptrs[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          back_to_back;

    first_fit_heap_allocator #(
        .HEAP_BYTES   (HEAP),
        .HEADER_BYTES (HDR)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .req_size     (req_size),
        .payload_addr (payload_addr),
        .busy         (busy),
        .done         (done),
        .result_addr  (result_addr),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_heap();
        for (int i = 0; i < HEAP; i++)
        begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = HEAP - HDR;
        blk_free[0] = 1'b1;
    endfunction

    function automatic grant_t predict_alloc(input logic [15:0] size_i);
        grant_t      g;
        int unsigned req;
        int unsigned a;
        int unsigned n;
        req      = 32'(size_i);
        a        = 0;
        g.addr   = '0;
        g.status = ffa_pkg::ST_NO_SPACE;
        if (req == 0)
        begin
            g.status = ffa_pkg::ST_ZERO_SIZE;
            return g;
        end
        if (req > HEAP - HDR)
        begin
            g.status = ffa_pkg::ST_TOO_LARGE;
            return g;
        end
        while (a < HEAP)
        begin
            if (blk_free[a] && blk_size[a] >= req)
            begin
                if (blk_size[a] > req + HDR)
                begin
                    n           = a + HDR + req;
                    blk_size[n] = blk_size[a] - req - HDR;
                    blk_free[n] = 1'b1;
                    blk_size[a] = req;
                end
                blk_free[a] = 1'b0;
                g.addr      = ffa_pkg::RES_ADDR_W'(a + HDR);
                g.status    = ffa_pkg::ST_OK;
                return g;
            end
            a = a + HDR + blk_size[a];
        end
        return g;
    endfunction

    function automatic grant_t predict_free(input logic [15:0] ptr_i);
        grant_t      g;
        int unsigned p;
        int unsigned target;
        int unsigned a;
        int unsigned prev;
        int unsigned nx;
        bit          has_prev;
        p        = 32'(ptr_i);
        a        = 0;
        prev     = 0;
        has_prev = 1'b0;
        g.addr   = '0;
        g.status = ffa_pkg::ST_OK;
        if (p == 0 || p > HEAP)
        begin
            g.status = ffa_pkg::ST_BAD_RANGE;
            return g;
        end
        if (p < HDR)
        begin
            g.status = ffa_pkg::ST_INVALID;
            return g;
        end
        target = p - HDR;
        while (a < HEAP && a != target)
        begin
            prev     = a;
            has_prev = 1'b1;
            a        = a + HDR + blk_size[a];
        end
        if (a != target || a >= HEAP)
        begin
            g.status = ffa_pkg::ST_INVALID;
            return g;
        end
        if (blk_free[a])
        begin
            g.status = ffa_pkg::ST_DBL_FREE;
            return g;
        end
        blk_free[a] = 1'b1;
        nx          = a + HDR + blk_size[a];
        if (nx < HEAP && blk_free[nx])
            blk_size[a] = blk_size[a] + HDR + blk_size[nx];
        if (has_prev && blk_free[prev])
            blk_size[prev] = blk_size[prev] + HDR + blk_size[a];
        return g;
    endfunction

    function automatic int pick_gap();
        int r;
        if (back_to_back)
            return 0;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic op_i, input logic [15:0] size_i,
                             input logic [15:0] ptr_i);
        int gap;
        int idx[$];
        @(negedge clk);
        start        = 1'b1;
        op           = op_i;
        req_size     = size_i;
        payload_addr = ptr_i;
        do
            @(posedge clk);
        while (busy);
        if (op_i == ffa_pkg::OP_ALLOC)
            last_grant = predict_alloc(size_i);
        else
            last_grant = predict_free(ptr_i);
        pending_grants.push_back(last_grant);
        if (last_grant.status == ffa_pkg::ST_OK)
        begin
            if (op_i == ffa_pkg::OP_ALLOC)
                live_ptrs.push_back(16'(last_grant.addr));
            else
            begin
                idx = live_ptrs.find_first_index(x) with (x == ptr_i);
                if (idx.size() != 0)
                    live_ptrs.delete(idx[0]);
                freed_ptrs.push_back(ptr_i);
                if (freed_ptrs.size() > 16)
                    void'(freed_ptrs.pop_front());
            end
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start        = 1'b0;
            op           = 1'($urandom);
            req_size     = 16'($urandom);
            payload_addr = 16'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_size_limits();
        send_item(ffa_pkg::OP_ALLOC, 16'd0, 16'($urandom));
        send_item(ffa_pkg::OP_ALLOC, 16'(HEAP - HDR + 1), 16'($urandom));
        send_item(ffa_pkg::OP_ALLOC, 16'hFFFF, 16'($urandom));
        send_item(ffa_pkg::OP_ALLOC, 16'(HEAP - HDR), 16'hFFFF);
        send_item(ffa_pkg::OP_ALLOC, 16'd1, 16'($urandom));
        send_item(ffa_pkg::OP_FREE, 16'hFFFF, 16'(HDR));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'(HDR));
    endtask

    task automatic test_pointer_checks();
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'd0);
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'(HEAP + 1));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'hFFFF);
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'(HEAP));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'(HDR - 1));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'(HDR + 24));
    endtask

    task automatic test_split_and_merge();
        logic [15:0] pa;
        logic [15:0] pb;
        logic [15:0] pc;
        send_item(ffa_pkg::OP_ALLOC, 16'd100, 16'($urandom));
        pa = 16'(last_grant.addr);
        send_item(ffa_pkg::OP_ALLOC, 16'd200, 16'($urandom));
        pb = 16'(last_grant.addr);
        send_item(ffa_pkg::OP_ALLOC, 16'd64, 16'($urandom));
        pc = 16'(last_grant.addr);
        send_item(ffa_pkg::OP_FREE, 16'($urandom), pb);
        // remainder too small for a header, block taken whole
        send_item(ffa_pkg::OP_ALLOC, 16'd190, 16'($urandom));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), pb);
        send_item(ffa_pkg::OP_ALLOC, 16'd200, 16'($urandom));
        send_item(ffa_pkg::OP_FREE, 16'($urandom), pb);
        send_item(ffa_pkg::OP_FREE, 16'($urandom), pa);
        // merges with the free tail and the free block before it
        send_item(ffa_pkg::OP_FREE, 16'($urandom), pc);
    endtask

    task automatic test_fill_and_empty();
        bit full;
        int count;
        int k;
        full  = 1'b0;
        count = 0;
        while (!full && count < 300)
        begin
            send_item(ffa_pkg::OP_ALLOC, 16'($urandom_range(1, 32)), 16'($urandom));
            if (last_grant.status == ffa_pkg::ST_NO_SPACE)
                full = 1'b1;
            count++;
        end
        wait_all_results();
        while (live_ptrs.size() != 0)
        begin
            k = $urandom_range(live_ptrs.size() - 1);
            send_item(ffa_pkg::OP_FREE, 16'($urandom), live_ptrs[k]);
        end
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        int          r;
        int          r2;
        logic [15:0] size_v;
        logic [15:0] ptr_v;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
                back_to_back = ($urandom_range(3) == 0);
            if (i % 200 == 199)
                wait_all_results();
            r = $urandom_range(99);
            if (r >= 50 && r < 85 && live_ptrs.size() == 0)
                r = 0;
            if (r >= 85 && r < 90 && freed_ptrs.size() == 0)
                r = 99;
            if (r < 50)
            begin
                r2 = $urandom_range(99);
                if (r2 < 70)
                    size_v = 16'($urandom_range(1, 128));
                else if (r2 < 85)
                    size_v = 16'($urandom_range(1, 1024));
                else if (r2 < 93)
                    size_v = 16'($urandom_range(1, HEAP - HDR));
                else if (r2 < 96)
                    size_v = 16'd0;
                else
                    size_v = 16'($urandom);
                send_item(ffa_pkg::OP_ALLOC, size_v, 16'($urandom));
            end
            else if (r < 85)
            begin
                ptr_v = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
                send_item(ffa_pkg::OP_FREE, 16'($urandom), ptr_v);
            end
            else if (r < 90)
            begin
                ptr_v = freed_ptrs[$urandom_range(freed_ptrs.size() - 1)];
                send_item(ffa_pkg::OP_FREE, 16'($urandom), ptr_v);
            end
            else if (r < 95 && live_ptrs.size() != 0)
            begin
                ptr_v = live_ptrs[$urandom_range(live_ptrs.size() - 1)]
                        + 16'($urandom_range(1, HDR));
                send_item(ffa_pkg::OP_FREE, 16'($urandom), ptr_v);
            end
            else
                send_item(ffa_pkg::OP_FREE, 16'($urandom), 16'($urandom));
        end
        back_to_back = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        grant_t exp_g;
        if (done === 1'b1)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result: result_addr %0d status %0d", result_addr, status);
                mismatch_count++;
            end
            else
            begin
                exp_g = pending_grants.pop_front();
                if (result_addr !== exp_g.addr)
                begin
                    $error("result_addr: expected %0d, actual %0d", exp_g.addr, result_addr);
                    mismatch_count++;
                end
                if (status !== exp_g.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_g.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = ffa_pkg::OP_ALLOC;
        req_size       = '0;
        payload_addr   = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        back_to_back   = 1'b0;
        clear_heap();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_size_limits();
        test_pointer_checks();
        test_split_and_merge();
        wait_all_results();
        test_fill_and_empty();
        test_random_traffic(800);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
